// ----- hw/rtl/comparison_count_ranker_top_assert.svh -----
// assertion macros for the comparison count ranker checker
// depends on nothing; included by the checker file
`ifndef COMPARISON_COUNT_RANKER_TOP_ASSERT_SVH
`define COMPARISON_COUNT_RANKER_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define CCR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define CCR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define CCR_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/ccr_pkg.sv -----
// shared constants and types of the comparison count ranker
// depends on nothing; used by every module of the block but ccr_ram
package ccr_pkg;

   localparam int MAX_LEN = 64;
   localparam int VALUE_W = 32;
   localparam int RANK_W  = 6;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int CNT_W   = $clog2(MAX_LEN + 1);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MINE,
      ST_SCAN,
      ST_WAIT,
      ST_PUT
   } ccr_state_type;

   typedef struct packed {
      logic load;
      logic mine_rd;
      logic scan;
      logic put;
   } ccr_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic elem_last;
      logic out_free;
   } ccr_status_type;

endpackage

// ----- hw/rtl/ccr_ram.sv -----
// generic single write port, single read port ram with registered read
// depends on nothing
module ccr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/ccr_ctrl.sv -----
// sequencer of the comparison count ranker: load, then rank element by element
// depends on ccr_pkg
module ccr_ctrl
   import ccr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_last,
   output logic           req_stall,
   input  ccr_status_type status,
   output ccr_cmd_type    cmd
);

   ccr_state_type state_ff;
   ccr_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_stall   = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
            if (req_valid && req_last) begin
               state_in = ST_MINE;
            end
         end
         ST_MINE: begin
            cmd.mine_rd = 1'b1;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_PUT;
         end
         ST_PUT: begin
            if (status.out_free) begin
               cmd.put  = 1'b1;
               state_in = status.elem_last ? ST_LOAD : ST_MINE;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

// ----- hw/rtl/ccr_datapath.sv -----
// value store, indexes, shared comparator, greater counter and result register
// depends on ccr_pkg and ccr_ram
module ccr_datapath
   import ccr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ccr_cmd_type        cmd,
   output ccr_status_type     status,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [RANK_W-1:0]  rsp_rank,
   output logic               rsp_last_res,
   output logic               rsp_overflow
);

   logic [CNT_W-1:0]   count_ff;
   logic               ovf_ff;
   logic [CNT_W-1:0]   n_ff;
   logic               rank_ovf_ff;
   logic [ADDR_W-1:0]  i_ff;
   logic [ADDR_W-1:0]  j_ff;
   logic [VALUE_W-1:0] mine_ff;
   logic [RANK_W-1:0]  greater_ff;
   logic               rd_mine_ff;
   logic               rd_cmp_ff;
   logic               rsp_valid_ff;
   logic [RANK_W-1:0]  rsp_rank_ff;
   logic               rsp_last_res_ff;
   logic               rsp_overflow_ff;

   logic               has_room;
   logic               wr_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [VALUE_W-1:0] rd_data;

   assign has_room = count_ff < CNT_W'(MAX_LEN);
   assign wr_en    = cmd.load && has_room;
   assign rd_addr  = cmd.mine_rd ? i_ff : j_ff;

   ccr_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // element count and dropped item flag
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.load) begin
         if (req_last) begin
            count_ff <= '0;
            ovf_ff   <= 1'b0;
         end else if (has_room) begin
            count_ff <= count_ff + CNT_W'(1);
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   // vector length and overflow captured at the final item
   always_ff @(posedge clock) begin
      if (cmd.load && req_last) begin
         n_ff        <= has_room ? count_ff + CNT_W'(1) : count_ff;
         rank_ovf_ff <= ovf_ff | ~has_room;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && req_last) begin
         i_ff <= '0;
      end else if (cmd.put) begin
         i_ff <= i_ff + ADDR_W'(1);
      end
      if (cmd.mine_rd) begin
         j_ff <= '0;
      end else if (cmd.scan) begin
         j_ff <= j_ff + ADDR_W'(1);
      end
   end

   // read kind tags line up with the registered read data
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_mine_ff <= 1'b0;
         rd_cmp_ff  <= 1'b0;
      end else begin
         rd_mine_ff <= cmd.mine_rd;
         rd_cmp_ff  <= cmd.scan;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_mine_ff) begin
         mine_ff <= rd_data;
      end
      if (cmd.mine_rd) begin
         greater_ff <= '0;
      end else if (rd_cmp_ff && ($signed(rd_data) > $signed(mine_ff))) begin
         greater_ff <= greater_ff + RANK_W'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.put) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.put) begin
         rsp_rank_ff     <= greater_ff;
         rsp_last_res_ff <= status.elem_last;
         rsp_overflow_ff <= rank_ovf_ff;
      end
   end

   assign status.scan_last = CNT_W'(j_ff) == n_ff - CNT_W'(1);
   assign status.elem_last = CNT_W'(i_ff) == n_ff - CNT_W'(1);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_rank     = rsp_rank_ff;
   assign rsp_last_res = rsp_last_res_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

// ----- hw/rtl/comparison_count_ranker_top.sv -----
// items are taken one per cycle while loading; after the final item each rank is
// formed in steps (one store read for the element, n reads through the single ram
// read port and one shared comparator, then drain and output load, which waits
// while a stalled result is held); one vector is ranked at a time
// reset: synchronous, clears the sequencer, element count, overflow flag and output valid
// top level of the comparison count ranker; depends on ccr_pkg, ccr_ctrl, ccr_datapath
module comparison_count_ranker_top
   import ccr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [RANK_W-1:0]  rsp_rank,
   output logic               rsp_last_res,
   output logic               rsp_overflow
);

   ccr_cmd_type    cmd;
   ccr_status_type status;

   ccr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ccr_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_value    (req_value),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_rank     (rsp_rank),
      .rsp_last_res (rsp_last_res),
      .rsp_overflow (rsp_overflow)
   );

endmodule

// ----- hw/rtl/ccr_checker.sv -----
// port level checks of the comparison count ranker, bound to the top level
// depends on ccr_pkg and comparison_count_ranker_top_assert.svh
`include "comparison_count_ranker_top_assert.svh"

module ccr_checker
   import ccr_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [VALUE_W-1:0] req_value,
   input logic               req_last,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [RANK_W-1:0]  rsp_rank,
   input logic               rsp_last_res,
   input logic               rsp_overflow
);

   logic unused_value;
   assign unused_value = ^req_value;

   // stalled result holds
   `CCR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_rank) && $stable(rsp_last_res) && $stable(rsp_overflow),
      "stalled result changed")

   // final item of a vector closes the input while ranking
   `CCR_ASSERT_NEXT(a_last_stalls, req_valid && !req_stall && req_last, req_stall,
      "input open right after final item")

   // mid-vector result means ranking is still running
   `CCR_ASSERT_NOW(a_mid_vector_busy, rsp_valid && !rsp_last_res, req_stall,
      "input open during ranking")

   // no result right after reset
   `CCR_ASSERT_ALWAYS(a_reset_quiet, reset, !rsp_valid, "result valid after reset")

endmodule

bind comparison_count_ranker_top ccr_checker u_ccr_checker (.*);

// ----- sim/comparison_count_ranker_checker.sv -----
// checker for the comparison count ranker: watches both channels, predicts the ranks
// of each loaded vector and compares every result item field by field
// depends on ccr_pkg
`timescale 1ns / 100ps
module comparison_count_ranker_checker
   import ccr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               req_last,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [RANK_W-1:0]  rsp_rank,
   input  logic               rsp_last_res,
   input  logic               rsp_overflow,
   output int                 fail_count,
   output int                 pending
);

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic              last_res;
      logic              overflow;
   } rank_result_type;

   logic signed [VALUE_W-1:0] loaded_values [MAX_LEN];
   int                        loaded_count;
   logic                      dropped;
   rank_result_type           expected_ranks [$];
   int                        errors;

   initial begin
      fail_count = 0;
      pending = 0;
      errors = 0;
      loaded_count = 0;
      dropped = 1'b0;
   end

   task automatic rank_vector();
      rank_result_type r;
      int greater;
      for (int i = 0; i < loaded_count; i++) begin
         greater = 0;
         for (int j = 0; j < loaded_count; j++) begin
            if (loaded_values[j] > loaded_values[i]) greater++;
         end
         r.rank = greater[RANK_W-1:0];
         r.last_res = (i == loaded_count - 1);
         r.overflow = dropped;
         expected_ranks.push_back(r);
      end
      loaded_count = 0;
      dropped = 1'b0;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      rank_result_type want;
      if (reset) begin
         loaded_count = 0;
         dropped = 1'b0;
         expected_ranks.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_ranks.size() == 0) begin
               $error("unexpected item: rank %0d last_res %0b overflow %0b",
                      rsp_rank, rsp_last_res, rsp_overflow);
               errors++;
            end else begin
               want = expected_ranks.pop_front();
               check_field("rank", want.rank, rsp_rank);
               check_field("last_res", want.last_res, rsp_last_res);
               check_field("overflow", want.overflow, rsp_overflow);
            end
         end
         if (req_valid && !req_stall) begin
            if (loaded_count < MAX_LEN) begin
               loaded_values[loaded_count] = req_value;
               loaded_count++;
            end else begin
               dropped = 1'b1;
            end
            if (req_last) rank_vector();
         end
      end
      fail_count <= errors;
      pending <= expected_ranks.size();
   end

endmodule

// ----- sim/comparison_count_ranker_top_test.sv -----
// testbench top for the comparison count ranker: drives vectors of values under
// several idle and stall settings and gives the verdict
// depends on ccr_pkg, comparison_count_ranker_top and comparison_count_ranker_checker
`timescale 1ns / 100ps
module comparison_count_ranker_top_test
   import ccr_pkg::*;
();

   localparam int QUIET_LIMIT = 5000;
   localparam int SMALL_ITEMS = 24;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [VALUE_W-1:0] req_value = '0;
   logic               req_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [RANK_W-1:0]  rsp_rank;
   logic               rsp_last_res;
   logic               rsp_overflow;

   int                 fail_count;
   int                 pending;
   int                 send_idle_pct = 0;
   int                 stall_pct = 0;
   int                 quiet_cycles = 0;
   logic [VALUE_W-1:0] vector_buf [$];

   comparison_count_ranker_top DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_rank     (rsp_rank),
      .rsp_last_res (rsp_last_res),
      .rsp_overflow (rsp_overflow)
   );

   comparison_count_ranker_checker rank_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_rank     (rsp_rank),
      .rsp_last_res (rsp_last_res),
      .rsp_overflow (rsp_overflow),
      .fail_count   (fail_count),
      .pending      (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("comparison_count_ranker_top_test failed");
            $finish;
         end
      end
   end

   task automatic send_item(input logic [VALUE_W-1:0] value, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_vector();
      for (int i = 0; i < vector_buf.size(); i++) begin
         send_item(vector_buf[i], i == vector_buf.size() - 1);
      end
      vector_buf.delete();
   endtask

   // mix of extremes, narrow ranges for ties and full-range values
   task automatic random_vector(input int len);
      logic [VALUE_W-1:0] v;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 7))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2, 3: v = $urandom_range(0, 6) - 3;
            default: v = $urandom;
         endcase
         vector_buf.push_back(v);
      end
      send_vector();
   endtask

   initial begin : stimulus
      int sent;
      int len;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // single element
      vector_buf = '{32'd7};
      send_vector();
      // extremes with duplicates
      vector_buf = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1,
                     32'h8000_0000, 32'h7FFF_FFFF};
      send_vector();
      // all equal
      vector_buf = '{32'd5, 32'd5, 32'd5, 32'd5};
      send_vector();
      // ascending through zero
      vector_buf = '{-32'sd3, -32'sd2, -32'sd1, 32'd0, 32'd1};
      send_vector();
      vector_buf = '{32'd100, -32'sd100};
      send_vector();
      vector_buf = '{32'hAAAA_AAAA, 32'h5555_5555};
      send_vector();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 81; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 81; end
            default: begin send_idle_pct = 29; stall_pct <= 29; end
         endcase
         sent = 0;
         while (sent < SMALL_ITEMS) begin
            len = $urandom_range(1, 10);
            random_vector(len);
            sent += len;
         end
         // full store, then a vector with dropped items and last on a dropped one
         if (phase == 1) random_vector(MAX_LEN);
         if (phase == 3) random_vector(MAX_LEN + 2);
      end
      req_valid <= 1'b0;

      // let the checker take in the final item before looking at its count
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("comparison_count_ranker_top_test passed");
      end else begin
         $display("comparison_count_ranker_top_test failed");
      end
      $finish;
   end

endmodule
